[src/a85_pkg.sv]
// Shared types and constants for the ASCII85 stream decoder.
// No dependencies; a85_decode, a85_pad and ascii85_stream_decoder import this package.
package a85_pkg;

    // Widths of the group accumulator: four digits stored, five on flush
    localparam int ACC_W = 26;
    localparam int GRP_W = 33;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] DIGIT_LO = 8'd33;
    localparam logic [7:0] DIGIT_HI = 8'd117;

    // Digit value of a '<' that turns out not to open a "<~" mark
    localparam logic [ACC_W-1:0] LT_DIGIT = ACC_W'(27);

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_CHAR        = 3'd1,
        ERR_Z_IN_GROUP  = 3'd2,
        ERR_SHORT_GROUP = 3'd3,
        ERR_OVERFLOW    = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        PK_ERROR,
        PK_ZERO,
        PK_GROUP,
        PK_MARK
    } pkt_kind_t;

    // One decoded character step, before padding and overflow check
    typedef struct packed {
        pkt_kind_t        kind;
        err_t             code;
        logic [GRP_W-1:0] value;
        logic [1:0]       pad;
        logic [1:0]       nbytes_m1;
        logic             last;
    } pkt_t;

    // Up to four results waiting for the output serializer
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  count_m1;
        logic        byte_valid;
        err_t        code;
        logic        last;
    } burst_t;

    // 85 to the power of the number of pad digits
    function automatic logic [19:0] pad_power(input logic [1:0] m);
        logic [19:0] p;
        case (m)
            2'd0:    p = 20'd1;
            2'd1:    p = 20'd85;
            2'd2:    p = 20'd7225;
            default: p = 20'd614125;
        endcase
        return p;
    endfunction

endpackage

[src/a85_stream_if.sv]
// Valid/ready channel interfaces for the ASCII85 decoder's character input
// and decoded byte output. No dependencies.
interface a85_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface a85_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       end_of_stream;
    logic [2:0] error_code;

    modport source (output valid, output data_byte, output byte_valid, output last_of_run,
                    output end_of_stream, output error_code, input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input last_of_run,
                    input end_of_stream, input error_code, output ready);
endinterface

[src/a85_decode.sv]
// Character classification, mark stripping and digit accumulation.
// Depends on a85_pkg. Emits at most one registered packet per character step.
module a85_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    char_in,
    input  logic          last_char,
    output logic          pkt_valid,
    input  logic          pkt_ready,
    output a85_pkg::pkt_t pkt
);
    import a85_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [1:0]       pos_reg;
    logic [7:0]       held_char_reg;
    logic             held_valid_reg;
    logic             failed_reg, failed_next;
    logic             pkt_valid_reg;
    pkt_t             pkt_reg, pkt_next;

    logic             accept;
    logic             trail, lead, skip, feed_held, hold_c, feed_c;
    logic             held_err, held_dig, live_c;
    logic             is_ws, is_digit, is_z;
    logic [ACC_W-1:0] acc1;
    logic [2:0]       cnt1;
    logic [GRP_W-1:0] acc_mul;
    logic             fire;

    assign in_ready  = !pkt_valid_reg || pkt_ready;
    assign accept    = in_valid && in_ready;
    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

    // Mark detection: "~>" at the end, "<~" as the first two characters
    assign trail = last_char && char_in == CH_GT && pos_reg != 2'd0
                   && held_char_reg == CH_TILDE;
    assign lead  = pos_reg == 2'd1 && held_valid_reg && held_char_reg == CH_LT
                   && char_in == CH_TILDE;
    assign skip      = trail || lead;
    assign feed_held = !skip && held_valid_reg;
    assign hold_c    = !skip && !last_char
                       && (char_in == CH_TILDE || (pos_reg == 2'd0 && char_in == CH_LT));
    assign feed_c    = !skip && !hold_c;

    // A held '<' only exists at the first position, so the group is empty then
    assign held_err = feed_held && !failed_reg && held_char_reg != CH_LT;
    assign held_dig = feed_held && !failed_reg && held_char_reg == CH_LT;
    assign acc1     = held_dig ? LT_DIGIT : acc_reg;
    assign cnt1     = held_dig ? 3'd1 : cnt_reg;
    assign live_c   = feed_c && !failed_reg && !held_err;

    assign is_ws    = char_in == CH_SPACE || char_in == CH_TAB || char_in == CH_CR
                      || char_in == CH_LF || char_in == CH_FF || char_in == CH_NUL;
    assign is_digit = char_in >= DIGIT_LO && char_in <= DIGIT_HI;
    assign is_z     = char_in == CH_Z;
    assign acc_mul  = GRP_W'(acc1) * GRP_W'(85) + GRP_W'(char_in - DIGIT_LO);

    always_comb
    begin
        pkt_next    = '0;
        pkt_next.kind = PK_MARK;
        pkt_next.code = ERR_NONE;
        fire        = 1'b0;
        acc_next    = acc1;
        cnt_next    = cnt1;
        failed_next = failed_reg;

        if (held_err)
        begin
            pkt_next.kind = PK_ERROR;
            pkt_next.code = ERR_CHAR;
            fire          = 1'b1;
            failed_next   = 1'b1;
            acc_next      = '0;
            cnt_next      = 3'd0;
        end
        else if (live_c && !is_ws)
        begin
            if (is_z && cnt1 == 3'd0)
            begin
                pkt_next.kind      = PK_ZERO;
                pkt_next.nbytes_m1 = 2'd3;
                fire               = 1'b1;
            end
            else if (is_digit)
            begin
                if (cnt1 == 3'd4)
                begin
                    pkt_next.kind      = PK_GROUP;
                    pkt_next.value     = acc_mul;
                    pkt_next.nbytes_m1 = 2'd3;
                    fire               = 1'b1;
                    acc_next           = '0;
                    cnt_next           = 3'd0;
                    // A full group above 32 bits fails the rest of the stream;
                    // the overflow result itself is formed downstream
                    failed_next        = acc_mul[GRP_W-1];
                end
                else
                begin
                    acc_next = acc_mul[ACC_W-1:0];
                    cnt_next = cnt1 + 3'd1;
                end
            end
            else
            begin
                pkt_next.kind = PK_ERROR;
                pkt_next.code = is_z ? ERR_Z_IN_GROUP : ERR_CHAR;
                fire          = 1'b1;
                failed_next   = 1'b1;
                acc_next      = '0;
                cnt_next      = 3'd0;
            end
        end

        // End of stream: close a partial group, padding is applied downstream
        if (last_char && !fire && !failed_next && cnt_next != 3'd0)
        begin
            fire = 1'b1;
            if (cnt_next == 3'd1)
            begin
                pkt_next.kind = PK_ERROR;
                pkt_next.code = ERR_SHORT_GROUP;
            end
            else
            begin
                pkt_next.kind      = PK_GROUP;
                pkt_next.value     = GRP_W'(acc_next);
                pkt_next.pad       = 2'(3'd5 - cnt_next);
                pkt_next.nbytes_m1 = 2'(cnt_next - 3'd2);
            end
        end

        if (last_char && !fire)
        begin
            pkt_next.kind = PK_MARK;
            fire          = 1'b1;
        end

        pkt_next.last = last_char;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            cnt_reg        <= 3'd0;
            pos_reg        <= 2'd0;
            held_char_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            failed_reg     <= 1'b0;
            pkt_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last_char)
                begin
                    acc_reg        <= '0;
                    cnt_reg        <= 3'd0;
                    pos_reg        <= 2'd0;
                    held_char_reg  <= 8'd0;
                    held_valid_reg <= 1'b0;
                    failed_reg     <= 1'b0;
                end
                else
                begin
                    acc_reg        <= acc_next;
                    cnt_reg        <= cnt_next;
                    held_char_reg  <= char_in;
                    held_valid_reg <= hold_c;
                    failed_reg     <= failed_next;
                    if (pos_reg != 2'd2)
                    begin
                        pos_reg <= pos_reg + 2'd1;
                    end
                end
            end

            if (accept && fire)
            begin
                pkt_valid_reg <= 1'b1;
            end
            else if (pkt_ready)
            begin
                pkt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && fire)
        begin
            pkt_reg <= pkt_next;
        end
    end

endmodule

[src/a85_pad.sv]
// Pads a short final group, checks the 32-bit range and forms the result burst.
// Depends on a85_pkg.
module a85_pad (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pkt_valid,
    output logic            pkt_ready,
    input  a85_pkg::pkt_t   pkt,
    output logic            burst_valid,
    input  logic            burst_ready,
    output a85_pkg::burst_t burst
);
    import a85_pkg::*;

    logic [19:0]      power;
    logic [52:0]      product;
    logic [GRP_W-1:0] padded;
    logic             burst_valid_reg;
    burst_t           burst_reg, burst_next;

    assign pkt_ready   = !burst_valid_reg || burst_ready;
    assign burst_valid = burst_valid_reg;
    assign burst       = burst_reg;

    // Padding with digit 84 n times adds 85^n - 1 after scaling by 85^n
    assign power   = pad_power(pkt.pad);
    assign product = 53'(pkt.value) * 53'(power);
    assign padded  = product[GRP_W-1:0] + GRP_W'(power - 20'd1);

    always_comb
    begin
        burst_next            = '0;
        burst_next.code       = ERR_NONE;
        burst_next.last       = pkt.last;
        unique case (pkt.kind)
            PK_ERROR:
            begin
                burst_next.code = pkt.code;
            end
            PK_ZERO:
            begin
                burst_next.count_m1   = 2'd3;
                burst_next.byte_valid = 1'b1;
            end
            PK_GROUP:
            begin
                if (padded[GRP_W-1])
                begin
                    burst_next.code = ERR_OVERFLOW;
                end
                else
                begin
                    burst_next.word       = padded[31:0];
                    burst_next.count_m1   = pkt.nbytes_m1;
                    burst_next.byte_valid = 1'b1;
                end
            end
            PK_MARK:
            begin
                burst_next.code = ERR_NONE;
            end
            default:
            begin
                burst_next.code = ERR_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
        end
        else if (pkt_ready)
        begin
            burst_valid_reg <= pkt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_valid && pkt_ready)
        begin
            burst_reg <= burst_next;
        end
    end

endmodule

[src/ascii85_stream_decoder.sv]
// ASCII85 stream decoder: one character in, zero to four result transfers out.
// Throughput: one character per cycle while each character yields at most one
// result and the output is ready; a character with more results holds the input back.
// Reset: rst_n clears all stream state, as does the transfer of a last character.
// Depends on a85_pkg, a85_stream_if, a85_decode and a85_pad.
module ascii85_stream_decoder (
    input  logic clk,
    input  logic rst_n,
    a85_char_if.sink   char_stream,
    a85_byte_if.source byte_stream
);
    import a85_pkg::*;

    // Stage 1: mark stripping, classification and the times-85 accumulate.
    // The decoder produces one packet per character step that has results.
    logic   pkt_valid, pkt_ready;
    pkt_t   pkt;

    a85_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (char_stream.valid),
        .in_ready  (char_stream.ready),
        .char_in   (char_stream.char_in),
        .last_char (char_stream.last_char),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt)
    );

    // Stage 2: pad a short final group and check the group against 32 bits.
    // The padding multiply sits here so it never chains with the accumulate.
    logic   burst_valid, burst_ready;
    burst_t burst;

    a85_pad u_pad (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt_valid   (pkt_valid),
        .pkt_ready   (pkt_ready),
        .pkt         (pkt),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst)
    );

    // Stage 3: output serializer. Holds one burst and hands out its results
    // most significant byte first, one transfer per cycle while the receiver is
    // ready. It reloads in the same cycle its final result transfers, so bursts stream without a gap.
    logic        ser_valid_reg;
    logic [31:0] word_reg;
    logic [1:0]  rem_reg;
    logic        bv_reg;
    err_t        code_reg;
    logic        last_reg;
    logic        final_xfer;

    assign final_xfer  = ser_valid_reg && byte_stream.ready && rem_reg == 2'd0;
    assign burst_ready = !ser_valid_reg || final_xfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            rem_reg       <= 2'd0;
        end
        else if (burst_ready)
        begin
            // Load the next burst, or go empty when none waits
            ser_valid_reg <= burst_valid;
            rem_reg       <= burst.count_m1;
        end
        else if (byte_stream.ready)
        begin
            // Advance to the next result of the current burst
            rem_reg <= rem_reg - 2'd1;
        end
    end

    // Payload: the word shifts left one byte per transfer
    always_ff @(posedge clk)
    begin
        if (burst_ready && burst_valid)
        begin
            word_reg <= burst.word;
            bv_reg   <= burst.byte_valid;
            code_reg <= burst.code;
            last_reg <= burst.last;
        end
        else if (ser_valid_reg && byte_stream.ready)
        begin
            word_reg <= {word_reg[23:0], 8'd0};
        end
    end

    // Error and end-marker results carry a zero word, so no masking is needed
    assign byte_stream.valid         = ser_valid_reg;
    assign byte_stream.data_byte     = word_reg[31:24];
    assign byte_stream.byte_valid    = bv_reg;
    assign byte_stream.last_of_run   = rem_reg == 2'd0;
    assign byte_stream.end_of_stream = rem_reg == 2'd0 && last_reg;
    assign byte_stream.error_code    = code_reg;

endmodule

[test/tb_ascii85_stream_decoder.sv]
// Self-checking testbench for ascii85_stream_decoder: directed and random character streams
// checked transfer by transfer against a behavioral decoder held in a scoreboard class.
// Depends on src/a85_pkg.sv, src/a85_stream_if.sv and the decoder RTL.
`timescale 1ns / 100ps

typedef struct {
    logic [7:0]     data;
    logic           byte_valid;
    logic           last_of_run;
    logic           eos;
    a85_pkg::err_t  code;
} a85_result_t;

class a85_byte_predictor;
    a85_result_t pending_bytes[$];
    a85_result_t step_out[$];

    // Decoder state
    logic [63:0] acc;
    int unsigned ndigits;
    int unsigned char_index;
    logic [7:0]  prev_char;
    bit          prev_pending;
    bit          aborted;

    int errors;
    int chars_seen;
    int streams_seen;
    int bytes_seen;
    int code_seen[5];

    function new();
        clear_state();
        errors = 0;
        chars_seen = 0;
        streams_seen = 0;
        bytes_seen = 0;
        foreach (code_seen[i]) code_seen[i] = 0;
    endfunction

    function void clear_state();
        acc = 0;
        ndigits = 0;
        char_index = 0;
        prev_char = 0;
        prev_pending = 0;
        aborted = 0;
    endfunction

    function int pending();
        return pending_bytes.size();
    endfunction

    function void push_result(logic [7:0] b, logic v, a85_pkg::err_t e);
        a85_result_t r;
        if (step_out.size() >= 4)
            return;
        r.data = b;
        r.byte_valid = v;
        r.last_of_run = 0;
        r.eos = 0;
        r.code = e;
        step_out.insert(step_out.size(), r);
    endfunction

    function void abort_stream(a85_pkg::err_t e);
        push_result(8'h00, 1'b0, e);
        aborted = 1;
        acc = 0;
        ndigits = 0;
    endfunction

    function void flush_group(int unsigned n);
        if (acc > 64'hFFFF_FFFF)
        begin
            abort_stream(a85_pkg::ERR_OVERFLOW);
            return;
        end
        for (int k = 0; k < n && k < 4; k++)
            push_result(8'(acc >> (24 - 8 * k)), 1'b1, a85_pkg::ERR_NONE);
        acc = 0;
        ndigits = 0;
    endfunction

    function void decode_char(logic [7:0] c);
        if (aborted)
            return;
        if (c == a85_pkg::CH_SPACE || c == a85_pkg::CH_TAB || c == a85_pkg::CH_CR ||
            c == a85_pkg::CH_LF || c == a85_pkg::CH_FF || c == a85_pkg::CH_NUL)
            return;
        if (c == a85_pkg::CH_Z && ndigits == 0)
        begin
            repeat (4) push_result(8'h00, 1'b1, a85_pkg::ERR_NONE);
            return;
        end
        if (c >= a85_pkg::DIGIT_LO && c <= a85_pkg::DIGIT_HI)
        begin
            acc = acc * 85 + 64'(c - a85_pkg::DIGIT_LO);
            ndigits++;
            if (ndigits >= 5)
                flush_group(4);
            return;
        end
        abort_stream(c == a85_pkg::CH_Z ? a85_pkg::ERR_Z_IN_GROUP : a85_pkg::ERR_CHAR);
    endfunction

    // Pad a partial group with the top digit at end of stream
    function void close_stream();
        int unsigned n;
        if (aborted || ndigits == 0)
            return;
        if (ndigits == 1)
        begin
            abort_stream(a85_pkg::ERR_SHORT_GROUP);
            return;
        end
        n = ndigits - 1;
        while (ndigits < 5)
        begin
            acc = acc * 85 + 84;
            ndigits++;
        end
        flush_group(n);
    endfunction

    // Note one accepted character and queue the results it causes
    function void note_char(logic [7:0] c, logic last);
        bit trail;
        bit lead;
        trail = last && c == a85_pkg::CH_GT && char_index >= 1 && prev_char == a85_pkg::CH_TILDE;
        lead = char_index == 1 && prev_pending && prev_char == a85_pkg::CH_LT &&
               c == a85_pkg::CH_TILDE;
        step_out.delete();
        chars_seen++;

        if (trail || lead)
            prev_pending = 0;
        else
        begin
            if (prev_pending)
            begin
                decode_char(prev_char);
                prev_pending = 0;
            end
            if (!last && (c == a85_pkg::CH_TILDE || (char_index == 0 && c == a85_pkg::CH_LT)))
                prev_pending = 1;
            else
                decode_char(c);
        end
        prev_char = c;
        if (char_index < 2)
            char_index++;

        if (last)
        begin
            close_stream();
            if (step_out.size() == 0)
                push_result(8'h00, 1'b0, a85_pkg::ERR_NONE);
        end
        if (step_out.size() > 0)
        begin
            step_out[step_out.size() - 1].last_of_run = 1;
            step_out[step_out.size() - 1].eos = last;
        end
        foreach (step_out[i]) pending_bytes.insert(pending_bytes.size(), step_out[i]);

        if (last)
        begin
            streams_seen++;
            clear_state();
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 30)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_byte(a85_result_t got);
        a85_result_t want;
        if (pending_bytes.size() == 0)
        begin
            report($sformatf("unexpected result data=%02h valid=%0b code=%0d",
                             got.data, got.byte_valid, got.code));
            return;
        end
        want = pending_bytes.pop_front();
        if (want.byte_valid)
            bytes_seen++;
        code_seen[want.code]++;
        if (got.data !== want.data)
            report($sformatf("data_byte %02h, want %02h", got.data, want.data));
        if (got.byte_valid !== want.byte_valid)
            report($sformatf("byte_valid %0b, want %0b", got.byte_valid, want.byte_valid));
        if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %0b, want %0b", got.last_of_run, want.last_of_run));
        if (got.eos !== want.eos)
            report($sformatf("end_of_stream %0b, want %0b", got.eos, want.eos));
        if (got.code !== want.code)
            report($sformatf("error_code %0d, want %0d", got.code, want.code));
    endtask
endclass

module tb_ascii85_stream_decoder;
    import a85_pkg::*;

    // Cycles without any transfer before the run is declared hung; covers the
    // long receiver hold-off plus the worst random stall many times over.
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_TAIL  = 20;
    localparam int PHASE_ITEMS = 70;

    logic clk;
    logic rst_n;

    a85_char_if char_if ();
    a85_byte_if byte_if ();

    ascii85_stream_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_if),
        .byte_stream (byte_if)
    );

    a85_byte_predictor decoder_model = new();

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         items_sent = 0;
    bit         hold_request = 0;
    int         quiet_cycles = 0;
    logic [7:0] stream_chars[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Character side
    // ---------------------------------------------------------------

    // Append one character to the stream being assembled
    function automatic void add_char(input logic [7:0] c);
        stream_chars.insert(stream_chars.size(), c);
    endfunction

    // Offer one character and hold it until its transfer. Ready is sampled at
    // the falling edge, where it is settled for the coming rising edge.
    task automatic send_char(input logic [7:0] c, input logic last);
        bit took;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            char_if.valid <= 1'b0;
            @(posedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_in   <= c;
        char_if.last_char <= last;
        do
        begin
            @(negedge clk);
            took = char_if.ready;
            @(posedge clk);
        end
        while (!took);
        // The transfer happened at this edge; predict its results now
        decoder_model.note_char(c, last);
        items_sent++;
    endtask

    // Send the assembled stream, flagging its final character
    task automatic send_stream();
        if (stream_chars.size() == 0)
            add_char(CH_SPACE);
        foreach (stream_chars[i])
            send_char(stream_chars[i], i == stream_chars.size() - 1);
    endtask

    // Drop in a whitespace or NUL now and then; the decoder must skip it
    function automatic void maybe_space();
        if ($urandom_range(0, 7) != 0)
            return;
        case ($urandom_range(0, 5))
            0:       add_char(CH_NUL);
            1:       add_char(CH_TAB);
            2:       add_char(CH_LF);
            3:       add_char(CH_FF);
            4:       add_char(CH_CR);
            default: add_char(CH_SPACE);
        endcase
    endfunction

    // Encode nb bytes held in the top of word: five digits for a full group,
    // nb+1 digits for a partial one, or at random 'z' for an all-zero full group.
    function automatic void add_group(int nb, logic [31:0] word);
        logic [63:0] v;
        logic [63:0] p;
        int          nd;
        v = 64'(word);
        p = 64'd52200625;
        nd = (nb == 4) ? 5 : nb + 1;
        if (nb == 4 && word == 32'h0 && $urandom_range(0, 1) == 1)
        begin
            add_char(CH_Z);
            maybe_space();
            return;
        end
        for (int i = 0; i < nd; i++)
        begin
            add_char(8'((v / p) % 85) + DIGIT_LO);
            p = p / 85;
            maybe_space();
        end
    endfunction

    function automatic void build_wellformed(int nbytes, bit lead, bit trail);
        logic [31:0] word;
        int          nb;
        int          left;
        stream_chars.delete();
        if (lead)
        begin
            add_char(CH_LT);
            add_char(CH_TILDE);
        end
        left = nbytes;
        while (left > 0)
        begin
            nb = (left > 4) ? 4 : left;
            case ($urandom_range(0, 5))
                0:       word = 32'h0;
                1:       word = 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            word = word & (32'hFFFF_FFFF << (8 * (4 - nb)));
            add_group(nb, word);
            left = left - nb;
        end
        if (trail)
        begin
            add_char(CH_TILDE);
            add_char(CH_GT);
        end
    endfunction

    // A well-formed stream with one fault planted in it
    function automatic void build_broken();
        int pos;
        case ($urandom_range(0, 3))
            0:
            begin
                // character above the digit range somewhere
                build_wellformed($urandom_range(1, 12), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                pos = $urandom_range(0, stream_chars.size() - 1);
                stream_chars[pos] = 8'($urandom_range(118, 255));
            end
            1:
            begin
                // stray 'z', often inside a group
                build_wellformed($urandom_range(1, 12), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                pos = $urandom_range(0, stream_chars.size());
                stream_chars.insert(pos, CH_Z);
            end
            2:
            begin
                // final group of a single digit
                build_wellformed(4 * $urandom_range(0, 2), 1'($urandom_range(0, 1)), 1'b0);
                add_char(8'($urandom_range(33, 117)));
                if ($urandom_range(0, 1) == 1)
                begin
                    add_char(CH_TILDE);
                    add_char(CH_GT);
                end
            end
            default:
            begin
                // group above 32 bits: leading 't' or 'u' always overflows
                build_wellformed(4 * $urandom_range(0, 1), 1'($urandom_range(0, 1)), 1'b0);
                add_char(8'($urandom_range(83, 84)) + DIGIT_LO);
                repeat (4) add_char(8'($urandom_range(33, 117)));
                if ($urandom_range(0, 1) == 1)
                begin
                    add_char(CH_TILDE);
                    add_char(CH_GT);
                end
            end
        endcase
    endfunction

    // Raw bytes, weighted toward the marker characters
    function automatic void build_noise();
        stream_chars.delete();
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 7))
                0:       add_char(CH_LT);
                1:       add_char(CH_TILDE);
                2:       add_char(CH_GT);
                3:       add_char(CH_Z);
                default: add_char(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // Send random streams until count more characters have been transferred
    task automatic run_random(input int count);
        int stop;
        int kind;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
                build_wellformed($urandom_range(0, 12), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
            else if (kind <= 7)
                build_broken();
            else
                build_noise();
            send_stream();
        end
    endtask

    // ---------------------------------------------------------------
    // Byte side
    // ---------------------------------------------------------------

    // Drive ready at random; on request, hold it low for a long stretch so
    // the decoder backs up and stalls its character input.
    initial
    begin
        byte_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                byte_if.ready <= 1'b0;
                for (int held = 1; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
                byte_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check each result transfer; sample at the falling edge so the values
    // are those present at the next rising edge.
    initial
    begin
        a85_result_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && byte_if.valid === 1'b1 && byte_if.ready === 1'b1)
            begin
                got.data        = byte_if.data_byte;
                got.byte_valid  = byte_if.byte_valid;
                got.last_of_run = byte_if.last_of_run;
                got.eos         = byte_if.end_of_stream;
                got.code        = err_t'(byte_if.error_code);
                decoder_model.check_byte(got);
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((char_if.valid === 1'b1 && char_if.ready === 1'b1) ||
                (byte_if.valid === 1'b1 && byte_if.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        char_if.valid = 1'b0;
        char_if.char_in = 8'h00;
        char_if.last_char = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender rarely idles, receiver mostly stalls
        send_idle_pct = 17;
        recv_idle_pct = 87;

        // Leading and trailing marks, 'z', LF skipped, two-digit partial group
        stream_chars = '{CH_LT, CH_TILDE, CH_Z, CH_LF, "8", "7", CH_TILDE, CH_GT};
        send_stream();
        // Overlapping marks: decodes to nothing but the end marker
        stream_chars = '{CH_LT, CH_TILDE, CH_GT};
        send_stream();
        // Skipped controls, all-ones group, then a final group of one
        stream_chars = '{CH_NUL, CH_TAB, CH_CR, CH_FF, "s", "8", "W", "-", "!", "u"};
        send_stream();
        // Four top digits padded at the end overflow 32 bits
        stream_chars = '{"u", "u", "u", "u"};
        send_stream();
        // Full group above 32 bits mid-stream: the digits after it are ignored
        stream_chars = '{"u", "u", "u", "u", "u", "!", "!", "!", "!", "!"};
        send_stream();
        // Top character value on its own: invalid character
        stream_chars = '{8'hFF};
        send_stream();
        // 'z' inside a group
        stream_chars = '{"!", CH_Z};
        send_stream();

        run_random(PHASE_ITEMS);

        // Phase two: the other way round
        send_idle_pct = 87;
        recv_idle_pct = 17;
        run_random(PHASE_ITEMS);

        // Phase three: no idling, with one long receiver hold-off up front
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1;
        run_random(PHASE_ITEMS);

        char_if.valid <= 1'b0;
        char_if.last_char <= 1'b0;

        // Drain, then give any stray result time to show up
        while (decoder_model.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        while (decoder_model.pending() > 0)
        begin
            decoder_model.report("expected result never arrived");
            void'(decoder_model.pending_bytes.pop_front());
        end

        $display("Run covered %0d streams, %0d characters, %0d decoded bytes",
                 decoder_model.streams_seen, decoder_model.chars_seen, decoder_model.bytes_seen);
        $display("Errors reported: invalid %0d, z in group %0d, short group %0d, overflow %0d",
                 decoder_model.code_seen[ERR_CHAR], decoder_model.code_seen[ERR_Z_IN_GROUP],
                 decoder_model.code_seen[ERR_SHORT_GROUP], decoder_model.code_seen[ERR_OVERFLOW]);
        if (decoder_model.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
src/a85_pkg.sv
src/a85_stream_if.sv
src/a85_decode.sv
src/a85_pad.sv
src/ascii85_stream_decoder.sv
test/tb_ascii85_stream_decoder.sv
